// ----- design/phdr_pkg.sv -----
// Shared types, codes and helper functions of the packet header parser.
// Used by phdr_parse, phdr_finish and packet_header_parser; no dependencies.
package phdr_pkg;

   // Channel payloads
   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_payload_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [3:0]  proto_class;
      logic [7:0]  ip_proto;
      logic [15:0] src_port;
      logic [15:0] dst_port;
      logic [31:0] tcp_seq;
      logic [3:0]  tcp_flags;
      logic [15:0] message_code;
      logic [31:0] src_ipv4;
      logic [31:0] dst_ipv4;
      logic [15:0] payload_offset;
      logic [15:0] payload_length;
   } rsp_payload_type;

   // Parse phases
   localparam logic [3:0] PH_LINK    = 4'd0;
   localparam logic [3:0] PH_FAIL    = 4'd1;
   localparam logic [3:0] PH_UNSUP   = 4'd2;
   localparam logic [3:0] PH_NONIP   = 4'd3;
   localparam logic [3:0] PH_ARP     = 4'd4;
   localparam logic [3:0] PH_V4      = 4'd5;
   localparam logic [3:0] PH_V4BAD   = 4'd6;
   localparam logic [3:0] PH_V6FIX   = 4'd7;
   localparam logic [3:0] PH_EXTWAIT = 4'd8;
   localparam logic [3:0] PH_EXTLEN  = 4'd9;
   localparam logic [3:0] PH_EXTBODY = 4'd10;
   localparam logic [3:0] PH_TRANS   = 4'd11;

   // Link kinds
   localparam logic [3:0] LK_ETHER   = 4'd0;
   localparam logic [3:0] LK_COOKED  = 4'd1;
   localparam logic [3:0] LK_COOKED2 = 4'd2;
   localparam logic [3:0] LK_NULL    = 4'd3;
   localparam logic [3:0] LK_LOOP    = 4'd4;
   localparam logic [3:0] LK_RAW     = 4'd5;
   localparam logic [3:0] LK_IPV4    = 4'd6;
   localparam logic [3:0] LK_IPV6    = 4'd7;
   localparam logic [3:0] LK_UNSUP   = 4'd8;

   // Network kinds
   localparam logic [1:0] NK_NONIP = 2'd0;
   localparam logic [1:0] NK_IPV4  = 2'd1;
   localparam logic [1:0] NK_IPV6  = 2'd2;
   localparam logic [1:0] NK_ARP   = 2'd3;

   // Result status and class codes
   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_TRUNC    = 2'd1;
   localparam logic [1:0] ST_UNSUP    = 2'd2;
   localparam logic [1:0] ST_OVERLONG = 2'd3;

   localparam logic [3:0] PC_NONE   = 4'd0;
   localparam logic [3:0] PC_TCP    = 4'd1;
   localparam logic [3:0] PC_UDP    = 4'd2;
   localparam logic [3:0] PC_ICMP   = 4'd3;
   localparam logic [3:0] PC_ICMPV6 = 4'd4;
   localparam logic [3:0] PC_OTHER  = 4'd5;
   localparam logic [3:0] PC_FRAG   = 4'd6;
   localparam logic [3:0] PC_ARP    = 4'd7;
   localparam logic [3:0] PC_NONIP  = 4'd8;

   // Protocol numbers and ethertypes
   localparam logic [7:0]  IPP_HOPOPT = 8'd0;
   localparam logic [7:0]  IPP_ICMP   = 8'd1;
   localparam logic [7:0]  IPP_TCP    = 8'd6;
   localparam logic [7:0]  IPP_UDP    = 8'd17;
   localparam logic [7:0]  IPP_ROUTE  = 8'd43;
   localparam logic [7:0]  IPP_AUTH   = 8'd51;
   localparam logic [7:0]  IPP_ICMPV6 = 8'd58;
   localparam logic [7:0]  IPP_DSTOPT = 8'd60;
   localparam logic [15:0] ET_VLAN    = 16'h8100;
   localparam logic [15:0] ET_QINQ    = 16'h88A8;
   localparam logic [15:0] ET_VLAN2   = 16'h9100;
   localparam logic [15:0] ET_IPV4    = 16'h0800;
   localparam logic [15:0] ET_IPV6    = 16'h86DD;
   localparam logic [15:0] ET_ARP     = 16'h0806;
   localparam logic [15:0] FRAG_MASK  = 16'h1FFF;
   localparam logic [16:0] END_MAX    = 17'h1FFFF;
   localparam logic [16:0] V6_FIXED   = 17'd40;

   // CSR map
   localparam logic [2:0] CSR_LINK_KIND = 3'd0;

   // Parser state carried between bytes
   typedef struct packed {
      logic [3:0]  phase;
      logic [15:0] network_start;
      logic [1:0]  ether_kind;
      logic [16:0] header_end;
      logic [16:0] declared_end;
      logic [7:0]  next_header;
      logic [15:0] transport_start;
      logic [31:0] src_addr;
      logic [31:0] dst_addr;
      logic [31:0] ports;
      logic [31:0] seq;
      logic [7:0]  tcp_flag_byte;
      logic [7:0]  tcp_off_byte;
      logic [15:0] udp_len;
      logic [7:0]  icmp_type;
      logic [15:0] arp_op;
      logic [15:0] frag_word;
      logic [7:0]  ext_next;
      logic [7:0]  arp_hlen;
      logic [7:0]  arp_plen;
      logic [15:0] arp_ptype;
   } parse_state_type;

   function automatic logic [1:0] kind_of(input logic [15:0] e);
      logic [1:0] k;
      k = NK_NONIP;
      if (e == ET_IPV4) k = NK_IPV4;
      else if (e == ET_IPV6) k = NK_IPV6;
      else if (e == ET_ARP) k = NK_ARP;
      return k;
   endfunction

   function automatic logic [1:0] family_kind(input logic [31:0] af);
      logic [1:0] k;
      k = NK_NONIP;
      if (af == 32'd2) k = NK_IPV4;
      else if (af == 32'd10 || af == 32'd23 || af == 32'd24 || af == 32'd28 || af == 32'd30)
         k = NK_IPV6;
      return k;
   endfunction

   function automatic logic is_ext(input logic [7:0] n);
      return n == IPP_HOPOPT || n == IPP_ROUTE || n == IPP_DSTOPT || n == IPP_AUTH;
   endfunction

   function automatic logic [3:0] phase_of_kind(input logic [1:0] k);
      logic [3:0] p;
      case (k)
         NK_IPV4: p = PH_V4;
         NK_IPV6: p = PH_V6FIX;
         NK_ARP:  p = PH_ARP;
         default: p = PH_NONIP;
      endcase
      return p;
   endfunction

   // Open the next header at byte h: either another extension or transport
   function automatic parse_state_type begin_hdr(input parse_state_type s,
                                                 input logic [16:0] h);
      parse_state_type r;
      r = s;
      r.header_end = h;
      r.transport_start = h[16] ? 16'hFFFF : h[15:0];
      if (is_ext(s.next_header) && ({1'b0, h} + 18'd2) <= {1'b0, s.declared_end})
         r.phase = PH_EXTWAIT;
      else
         r.phase = PH_TRANS;
      return r;
   endfunction

endpackage

// ----- design/phdr_parse.sv -----
// Byte-by-byte parser state: link header, network header and transport capture.
// Depends on phdr_pkg.
module phdr_parse #(
   parameter int MAX_FRAME_BYTES = 65535
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     step,
   input  logic [7:0]               data_byte,
   input  logic                     last_byte,
   input  logic [3:0]               link_kind,
   output phdr_pkg::parse_state_type state_next,
   output logic [16:0]              frame_len
);
   import phdr_pkg::*;

   localparam logic [16:0] MAX_LEN = 17'(MAX_FRAME_BYTES);

   parse_state_type st_ff, st_in;
   logic [15:0]     byte_count_ff, byte_count_in;
   logic [31:0]     shift_ff, shift_in;

   logic [15:0] pos, rel, trel, sw16;
   logic [31:0] sw, le;
   logic [17:0] e18;
   logic [16:0] h17;
   logic [1:0]  fk;
   logic        do_net, do_trans;

   // Next parser state for the byte in flight
   always_comb begin
      st_in = st_ff;
      pos = byte_count_ff;
      sw = {shift_ff[23:0], data_byte};
      sw16 = sw[15:0];
      le = {sw[7:0], sw[15:8], sw[23:16], sw[31:24]};
      do_net = 1'b0;
      do_trans = 1'b0;
      rel = '0;
      trel = '0;
      e18 = '0;
      h17 = '0;
      fk = NK_NONIP;
      if ({1'b0, pos} < MAX_LEN) begin
         if (pos == 16'd0) begin
            // Start of frame: clear per-frame state
            st_in = '0;
            st_in.phase = (link_kind >= LK_UNSUP) ? PH_UNSUP : PH_LINK;
            st_in.header_end = 17'd13;
            st_in.declared_end = END_MAX;
            case (link_kind)
               LK_RAW: begin
                  if (data_byte[7:4] == 4'd4) begin
                     st_in.ether_kind = NK_IPV4;
                     st_in.phase = PH_V4;
                     do_net = 1'b1;
                  end else if (data_byte[7:4] == 4'd6) begin
                     st_in.ether_kind = NK_IPV6;
                     st_in.phase = PH_V6FIX;
                     do_net = 1'b1;
                  end else begin
                     st_in.phase = PH_FAIL;
                  end
               end
               LK_IPV4: begin
                  st_in.ether_kind = NK_IPV4;
                  st_in.phase = PH_V4;
                  do_net = 1'b1;
               end
               LK_IPV6: begin
                  st_in.ether_kind = NK_IPV6;
                  st_in.phase = PH_V6FIX;
                  do_net = 1'b1;
               end
               default: ;
            endcase
         end else if (st_ff.phase == PH_LINK) begin
            case (link_kind)
               LK_ETHER: begin
                  if ({1'b0, pos} == st_ff.header_end) begin
                     if (sw16 == ET_VLAN || sw16 == ET_QINQ || sw16 == ET_VLAN2) begin
                        st_in.header_end = st_ff.header_end + 17'd4;
                     end else begin
                        h17 = st_ff.header_end + 17'd1;
                        st_in.network_start = h17[15:0];
                        st_in.ether_kind = kind_of(sw16);
                        st_in.phase = phase_of_kind(kind_of(sw16));
                     end
                  end
               end
               LK_COOKED: begin
                  if (pos == 16'd15) begin
                     st_in.network_start = 16'd16;
                     st_in.ether_kind = kind_of(sw16);
                     st_in.phase = phase_of_kind(kind_of(sw16));
                  end
               end
               LK_COOKED2: begin
                  if (pos == 16'd1) st_in.ether_kind = kind_of(sw16);
                  if (pos == 16'd19) begin
                     st_in.network_start = 16'd20;
                     st_in.phase = phase_of_kind(st_in.ether_kind);
                  end
               end
               LK_NULL, LK_LOOP: begin
                  if (pos == 16'd3) begin
                     fk = (link_kind == LK_NULL) ? family_kind(le) : NK_NONIP;
                     if (fk == NK_NONIP) fk = family_kind(sw);
                     if (fk != NK_NONIP) begin
                        st_in.network_start = 16'd4;
                        st_in.ether_kind = fk;
                        st_in.phase = phase_of_kind(fk);
                     end
                  end else if (pos == 16'd4) begin
                     // Fall back on the version nibble
                     if (data_byte[7:4] == 4'd4) begin
                        st_in.network_start = 16'd4;
                        st_in.ether_kind = NK_IPV4;
                        st_in.phase = PH_V4;
                        do_net = 1'b1;
                     end else if (data_byte[7:4] == 4'd6) begin
                        st_in.network_start = 16'd4;
                        st_in.ether_kind = NK_IPV6;
                        st_in.phase = PH_V6FIX;
                        do_net = 1'b1;
                     end else begin
                        st_in.phase = PH_FAIL;
                     end
                  end
               end
               default: ;
            endcase
         end else if (st_ff.phase >= PH_ARP) begin
            do_net = 1'b1;
         end
      end

      // Network layer walk
      if (do_net && pos >= st_in.network_start) begin
         rel = pos - st_in.network_start;
         case (st_in.phase)
            PH_V4: begin
               if (rel == 16'd0) begin
                  if (data_byte[7:4] != 4'd4 || data_byte[3:0] < 4'd5) begin
                     st_in.phase = PH_V4BAD;
                  end else begin
                     h17 = {1'b0, st_in.network_start} + {11'd0, data_byte[3:0], 2'b00};
                     st_in = begin_hdr(st_in, h17);
                     st_in.phase = PH_V4;
                  end
               end else if (rel == 16'd3) begin
                  st_in.declared_end = {1'b0, st_in.network_start} + {1'b0, sw16};
               end else if (rel == 16'd7) begin
                  st_in.frag_word = sw16;
               end else if (rel == 16'd9) begin
                  st_in.next_header = data_byte;
               end else if (rel == 16'd15) begin
                  st_in.src_addr = sw;
               end else if (rel == 16'd19) begin
                  st_in.dst_addr = sw;
               end
               if (rel >= 16'd20) do_trans = 1'b1;
            end
            PH_V6FIX: begin
               if (rel == 16'd5) begin
                  e18 = {2'b0, st_in.network_start} + 18'd40 + {2'b0, sw16};
                  st_in.declared_end = e18[17] ? END_MAX : e18[16:0];
               end else if (rel == 16'd6) begin
                  st_in.next_header = data_byte;
               end else if (rel == 16'd39) begin
                  st_in = begin_hdr(st_in, {1'b0, st_in.network_start} + V6_FIXED);
               end
            end
            PH_EXTWAIT: begin
               st_in.ext_next = data_byte;
               st_in.phase = PH_EXTLEN;
            end
            PH_EXTLEN: begin
               if (st_in.next_header == IPP_AUTH)
                  e18 = {1'b0, st_in.header_end} + {6'd0, ({2'b0, data_byte} + 10'd2), 2'b00};
               else
                  e18 = {1'b0, st_in.header_end} + {6'd0, ({1'b0, data_byte} + 9'd1), 3'b000};
               if (e18 > {1'b0, st_in.declared_end}) begin
                  st_in.phase = PH_TRANS;
               end else begin
                  st_in.header_end = e18[16:0];
                  st_in.phase = PH_EXTBODY;
               end
            end
            PH_EXTBODY: begin
               if (({1'b0, pos} + 17'd1) == st_in.header_end) begin
                  st_in.next_header = st_in.ext_next;
                  st_in = begin_hdr(st_in, st_in.header_end);
               end
            end
            PH_TRANS: do_trans = 1'b1;
            PH_ARP: begin
               if (rel == 16'd3) st_in.arp_ptype = sw16;
               else if (rel == 16'd4) st_in.arp_hlen = data_byte;
               else if (rel == 16'd5) st_in.arp_plen = data_byte;
               else if (rel == 16'd7) st_in.arp_op = sw16;
               if (rel >= 16'd8) begin
                  if ({1'b0, rel} == 17'd11 + {9'd0, st_in.arp_hlen})
                     st_in.src_addr = sw;
                  if ({1'b0, rel} == 17'd15 + {8'd0, st_in.arp_hlen, 1'b0})
                     st_in.dst_addr = sw;
               end
            end
            default: ;
         endcase
      end

      // Transport header capture
      if (do_trans && pos >= st_in.transport_start) begin
         trel = pos - st_in.transport_start;
         if (trel == 16'd0) st_in.icmp_type = data_byte;
         else if (trel == 16'd3) st_in.ports = sw;
         else if (trel == 16'd5) st_in.udp_len = sw16;
         else if (trel == 16'd7) st_in.seq = sw;
         else if (trel == 16'd12) st_in.tcp_off_byte = data_byte;
         else if (trel == 16'd13) st_in.tcp_flag_byte = data_byte;
      end

      // Byte counter saturates; last byte rearms the frame
      byte_count_in = (byte_count_ff != 16'hFFFF) ? byte_count_ff + 16'd1 : byte_count_ff;
      shift_in = sw;
      if (last_byte) begin
         byte_count_in = '0;
         shift_in = '0;
      end
   end

   assign state_next = st_in;
   assign frame_len = {1'b0, pos} + 17'd1;

   // Advance state on each transfer into this stage
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= '0;
         st_ff.phase <= PH_LINK;
         st_ff.declared_end <= END_MAX;
         byte_count_ff <= '0;
         shift_ff <= '0;
      end else if (step) begin
         st_ff <= st_in;
         byte_count_ff <= byte_count_in;
         shift_ff <= shift_in;
      end
   end

endmodule

// ----- design/phdr_finish.sv -----
// Result assembly from the final parser state of a frame.
// Depends on phdr_pkg.
module phdr_finish #(
   parameter int MAX_FRAME_BYTES = 65535
) (
   input  phdr_pkg::parse_state_type st,
   input  logic [16:0]              frame_len,
   output phdr_pkg::rsp_payload_type result
);
   import phdr_pkg::*;

   localparam logic [16:0] MAX_LEN = 17'(MAX_FRAME_BYTES);

   logic [17:0] len, n, t, pe, de, ue, po, hl, hdr;
   logic [7:0]  f;

   always_comb begin
      result = '0;
      len = {1'b0, frame_len};
      n = {2'b0, st.network_start};
      t = {2'b0, st.transport_start};
      pe = (frame_len < st.declared_end) ? len : {1'b0, st.declared_end};
      hdr = {1'b0, st.header_end};
      f = st.tcp_flag_byte;
      hl = {12'd0, st.tcp_off_byte[7:4], 2'b00};
      de = '0;
      ue = '0;
      po = '0;
      if (frame_len > MAX_LEN) begin
         result.status = ST_OVERLONG;
      end else begin
         case (st.phase)
            PH_UNSUP: result.status = ST_UNSUP;
            PH_LINK, PH_FAIL: result.status = ST_TRUNC;
            PH_NONIP: result.proto_class = PC_NONIP;
            PH_ARP: begin
               result.proto_class = PC_ARP;
               if (len >= n + 18'd8) begin
                  result.message_code = st.arp_op;
                  if (st.arp_ptype == ET_IPV4 && st.arp_plen == 8'd4 &&
                      len >= n + 18'd16 + {9'd0, st.arp_hlen, 1'b0}) begin
                     result.src_ipv4 = st.src_addr;
                     result.dst_ipv4 = st.dst_addr;
                  end
               end
            end
            PH_V4, PH_EXTWAIT, PH_EXTLEN, PH_EXTBODY, PH_TRANS: begin
               if (st.phase == PH_V4 &&
                   (len < n + 18'd20 || len < hdr || st.declared_end < st.header_end)) begin
                  result.proto_class = PC_NONE;
               end else if (st.phase == PH_V4 && (st.frag_word & FRAG_MASK) != 16'd0) begin
                  result.src_ipv4 = st.src_addr;
                  result.dst_ipv4 = st.dst_addr;
                  result.proto_class = PC_FRAG;
                  result.ip_proto = st.next_header;
               end else begin
                  if (st.phase == PH_V4) begin
                     result.src_ipv4 = st.src_addr;
                     result.dst_ipv4 = st.dst_addr;
                  end
                  // Transport layer
                  result.ip_proto = st.next_header;
                  case (st.next_header)
                     IPP_TCP: begin
                        result.proto_class = PC_TCP;
                        if (pe >= t + 18'd20) begin
                           result.src_port = st.ports[31:16];
                           result.dst_port = st.ports[15:0];
                           result.tcp_seq = st.seq;
                           result.tcp_flags = {f[4], f[2:0]};
                           po = t + hl;
                           if (hl >= 18'd20 && pe >= po && po < pe) begin
                              result.payload_offset = po[15:0];
                              result.payload_length = 16'(pe - po);
                           end
                        end
                     end
                     IPP_UDP: begin
                        result.proto_class = PC_UDP;
                        if (pe >= t + 18'd8) begin
                           result.src_port = st.ports[31:16];
                           result.dst_port = st.ports[15:0];
                           de = (st.udp_len >= 16'd8) ? t + {2'b0, st.udp_len} : pe;
                           ue = (pe < de) ? pe : de;
                           po = t + 18'd8;
                           if (po < ue) begin
                              result.payload_offset = po[15:0];
                              result.payload_length = 16'(ue - po);
                           end
                        end
                     end
                     IPP_ICMP, IPP_ICMPV6: begin
                        result.proto_class = (st.next_header == IPP_ICMP) ? PC_ICMP : PC_ICMPV6;
                        if (pe >= t + 18'd2) result.message_code = {8'd0, st.icmp_type};
                     end
                     default: result.proto_class = PC_OTHER;
                  endcase
               end
            end
            default: ;
         endcase
      end
   end

endmodule

// ----- design/packet_header_parser.sv -----
// Top level of the packet header parser: channels, CSR and result register.
// Depends on phdr_pkg, phdr_parse and phdr_finish.
//
// Usage: frame bytes enter on the req_ channel, one per transfer, with
// last_byte set on the final byte of each frame. Each frame gives exactly
// one result transfer on the rsp_ channel; other bytes give none.
// link_kind (CSR at byte address 0) selects the link header format; the user
// must write it only while no frame is in progress; the block does not enforce this.
// Timing: a transferred byte sits in the input register and is parsed from
// there; the result of a frame's last byte is captured into the result
// register when the pipe advances, and is then presented on rsp_valid.
// Throughput: one byte per cycle while rsp_ready does not stall the pipe, set
// by the combinational parse stage between the input and result registers.
// Stall: while a result is held and rsp_ready is low, the whole pipe holds
// and req_ready is low; it rises again in the cycle the result transfers.
// Reset: synchronous; link_kind returns to ethernet, both registers empty,
// byte count and parser state cleared.
module packet_header_parser #(
   parameter int MAX_FRAME_BYTES = 65535
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  phdr_pkg::req_payload_type req_payload,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output phdr_pkg::rsp_payload_type rsp_payload,
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [2:0]                csr_paddr,
   input  logic [31:0]               csr_pwdata,
   output logic [31:0]               csr_prdata,
   output logic                      csr_pready
);
   import phdr_pkg::*;

   logic            advance;
   logic            in_valid_ff;
   req_payload_type in_ff;
   logic [3:0]      link_kind_ff;
   logic            rsp_valid_ff;
   rsp_payload_type rsp_ff;
   parse_state_type state_next;
   logic [16:0]     frame_len;
   rsp_payload_type result;

   // Pipe moves whenever the result register is free or draining
   assign advance = !rsp_valid_ff || rsp_ready;
   assign req_ready = advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_ff;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == CSR_LINK_KIND) ? {28'd0, link_kind_ff} : 32'd0;

   // CSR write
   always_ff @(posedge clock) begin
      if (reset) begin
         link_kind_ff <= LK_ETHER;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_paddr == CSR_LINK_KIND) begin
         link_kind_ff <= csr_pwdata[3:0];
      end
   end

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (advance) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         in_ff <= req_payload;
      end
   end

   phdr_parse #(
      .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
   ) u_parse (
      .clock(clock),
      .reset(reset),
      .step(advance && in_valid_ff),
      .data_byte(in_ff.data_byte),
      .last_byte(in_ff.last_byte),
      .link_kind(link_kind_ff),
      .state_next(state_next),
      .frame_len(frame_len)
   );

   phdr_finish #(
      .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
   ) u_finish (
      .st(state_next),
      .frame_len(frame_len),
      .result(result)
   );

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= in_valid_ff && in_ff.last_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && in_valid_ff && in_ff.last_byte) begin
         rsp_ff <= result;
      end
   end

   a_last_gives_result: assert property (@(posedge clock) disable iff (reset)
      advance && in_valid_ff && in_ff.last_byte |=> rsp_valid_ff)
      else $error("last byte did not produce a result");

   a_no_spurious_result: assert property (@(posedge clock) disable iff (reset)
      advance && !(in_valid_ff && in_ff.last_byte) |=> !rsp_valid_ff)
      else $error("result without a last byte");

   a_overlong_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.status == ST_OVERLONG |-> rsp_ff.proto_class == PC_NONE)
      else $error("overlong frame carries a class");

   a_link_fail_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_ff.status == ST_TRUNC || rsp_ff.status == ST_UNSUP)
      |-> rsp_ff.ip_proto == 8'd0 && rsp_ff.proto_class == PC_NONE)
      else $error("link failure carries fields");

endmodule
